### sv/mmn_pkg.sv
// Package for the 53x53 mantissa multiplier with normalization shift.
// Holds the widths, constants and stage payload types; no dependencies.
package mmn_pkg;

  localparam int unsigned MantW  = 53;
  localparam int unsigned LoW    = 27;   // low slice of each mantissa
  localparam int unsigned HiW    = 26;   // high slice of each mantissa
  localparam int unsigned P00W   = 54;   // LoW x LoW
  localparam int unsigned PXW    = 53;   // LoW x HiW
  localparam int unsigned P11W   = 52;   // HiW x HiW
  localparam int unsigned MidW   = 54;   // sum of the two cross products
  localparam int unsigned ProdW  = 106;
  localparam int unsigned LowW   = 64;
  localparam int unsigned HighW  = 42;
  localparam int unsigned ShiftW = 7;
  localparam int unsigned GrpW   = 8;    // bits per leading-zero group
  localparam int unsigned GrpN   = 14;   // groups over the padded product
  localparam int unsigned PadW   = GrpW * GrpN - ProdW;
  localparam int unsigned GrpCntW = 3;

  localparam logic [ShiftW-1:0] ShiftOvf = 7'h7F;

  // Output of the partial product section: the non-overlapping products
  // already placed side by side, and the summed cross products.
  typedef struct packed {
    logic [ProdW-1:0] base;
    logic [MidW-1:0]  mid;
  } pp_sum_t;

  // Result fields of one transfer on the output channel.
  typedef struct packed {
    logic [LowW-1:0]   product_low;
    logic [HighW-1:0]  product_high;
    logic [ShiftW-1:0] norm_shift;
    logic              overflow_flag;
  } result_t;

endpackage

### sv/mmn_in_if.sv
// Input channel of the mantissa multiplier: valid/ready plus both operands.
// Depends on mmn_pkg for the operand width.
interface mmn_in_if import mmn_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MantW-1:0] mant_a;
  logic [MantW-1:0] mant_b;

  modport source (output valid, output mant_a, output mant_b, input ready);
  modport sink   (input valid, input mant_a, input mant_b, output ready);
endinterface

### sv/mmn_out_if.sv
// Output channel of the mantissa multiplier: valid/ready plus result fields.
// Depends on mmn_pkg for the field widths.
interface mmn_out_if import mmn_pkg::*;;
  logic              valid;
  logic              ready;
  logic [LowW-1:0]   product_low;
  logic [HighW-1:0]  product_high;
  logic [ShiftW-1:0] norm_shift;
  logic              overflow_flag;

  modport source (output valid, output product_low, output product_high,
                  output norm_shift, output overflow_flag, input ready);
  modport sink   (input valid, input product_low, input product_high,
                  input norm_shift, input overflow_flag, output ready);
endinterface

### sv/mmn_pp.sv
// Partial product section: four slice multiplies, then the cross-term add.
// Two register stages; depends on mmn_pkg.
module mmn_pp import mmn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [MantW-1:0] mant_a_i,
  input  logic [MantW-1:0] mant_b_i,
  output logic             valid_o,
  input  logic             ready_i,
  output pp_sum_t          data_o
);

  logic [LoW-1:0]  a0, b0;
  logic [HiW-1:0]  a1, b1;
  logic [P00W-1:0] p00_d, p00_q;
  logic [PXW-1:0]  p01_d, p01_q, p10_d, p10_q;
  logic [P11W-1:0] p11_d, p11_q;
  logic            v1_q, v2_q;
  logic            rdy1, rdy2;
  pp_sum_t         sum_d, sum_q;

  assign a0 = mant_a_i[LoW-1:0];
  assign a1 = mant_a_i[MantW-1:LoW];
  assign b0 = mant_b_i[LoW-1:0];
  assign b1 = mant_b_i[MantW-1:LoW];

  assign p00_d = P00W'(a0) * P00W'(b0);
  assign p01_d = PXW'(a0) * PXW'(b1);
  assign p10_d = PXW'(a1) * PXW'(b0);
  assign p11_d = P11W'(a1) * P11W'(b1);

  // The low and high products do not overlap, so they sit side by side.
  assign sum_d.base = {p11_q, p00_q};
  assign sum_d.mid  = MidW'(p01_q) + MidW'(p10_q);

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign data_o  = sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      p00_q <= p00_d;
      p01_q <= p01_d;
      p10_q <= p10_d;
      p11_q <= p11_d;
    end
    if (v1_q && rdy2) begin
      sum_q <= sum_d;
    end
  end

endmodule

### sv/mmn_sum.sv
// Final product add: places the cross terms at bit 27 and adds them in.
// One register stage; depends on mmn_pkg.
module mmn_sum import mmn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  pp_sum_t          data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_d, prod_q;
  logic             v_q;

  assign prod_d  = data_i.base + {(ProdW - MidW - LoW)'(0), data_i.mid, LoW'(0)};
  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign prod_o  = prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

endmodule

### sv/mmn_lzc.sv
// Leading-zero count and normalization shift over the 106-bit product.
// Per-group counts in the first stage, priority combine in the second.
// Depends on mmn_pkg.
module mmn_lzc import mmn_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ProdW-1:0] prod_i,
  output logic             valid_o,
  input  logic             ready_i,
  output result_t          res_o
);

  logic [GrpW*GrpN-1:0]   padded;
  logic [GrpN-1:0]        nz_d, nz_q;
  logic [GrpCntW-1:0]     cnt_d [GrpN];
  logic [GrpCntW-1:0]     cnt_q [GrpN];
  logic [ProdW-1:0]       prod_q;
  logic [ShiftW-1:0]      lzc;
  logic                   v1_q, v2_q;
  logic                   rdy1, rdy2;
  result_t                res_d, res_q;

  // Zero padding at the bottom does not change the count from the top.
  assign padded = {prod_i, PadW'(0)};

  // Group 0 is the most significant byte of the padded product.
  always_comb begin
    logic [GrpW-1:0] grp;
    for (int g = 0; g < GrpN; g++) begin
      grp      = padded[GrpW*(GrpN-g)-1 -: GrpW];
      nz_d[g]  = |grp;
      cnt_d[g] = '0;
      for (int k = 0; k < GrpW; k++) begin
        if (grp[k]) begin
          cnt_d[g] = GrpCntW'(GrpW - 1 - k);
        end
      end
    end
  end

  always_comb begin
    lzc = '0;
    for (int g = GrpN - 1; g >= 0; g--) begin
      if (nz_q[g]) begin
        lzc = {4'(g), cnt_q[g]};
      end
    end
  end

  // The shift is the leading-zero count less one, since the leading one
  // belongs at bit 104 rather than bit 105.
  always_comb begin
    res_d.product_low   = prod_q[LowW-1:0];
    res_d.product_high  = prod_q[ProdW-1:LowW];
    res_d.overflow_flag = prod_q[ProdW-1];
    if (nz_q == '0) begin
      res_d.norm_shift = '0;
    end else if (prod_q[ProdW-1]) begin
      res_d.norm_shift = ShiftOvf;
    end else begin
      res_d.norm_shift = lzc - ShiftW'(1);
    end
  end

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy1) begin
      prod_q <= prod_i;
      nz_q   <= nz_d;
      cnt_q  <= cnt_d;
    end
    if (v1_q && rdy2) begin
      res_q <= res_d;
    end
  end

endmodule

### sv/mantissa_multiplier_53x53_norm_top.sv
// Top level of the 53x53 mantissa multiplier with normalization shift.
// Instantiates mmn_pp, mmn_sum and mmn_lzc; depends on mmn_pkg and the
// channel interfaces mmn_in_if and mmn_out_if.
//
// Usage: operands arrive on in_i (mant_a, mant_b, unsigned 53 bits) with a
// valid/ready transfer. Each input transfer produces exactly one transfer on
// out_o carrying the full 106-bit product (product_high holds bits 105..64,
// product_low bits 63..0), the left shift that brings the leading one to
// bit 104, and an overflow flag for a product with bit 105 set; in that
// case the shift reads 127. A zero product reports a shift of 0.
//
// The datapath is a five-stage pipeline: slice multiplies, cross-term add,
// final 106-bit add, per-byte leading-zero count, shift combine. One operand
// pair is taken every cycle while the receiver keeps ready high.
//
// Each stage holds its own valid bit. When the receiver stalls, the last
// stage holds its result and earlier stages keep filling any empty slots,
// so in_i.ready drops only once all five stages hold data. Nothing is lost
// or repeated across a stall. Reset clears all valid bits; the data
// registers are not reset.
module mantissa_multiplier_53x53_norm_top import mmn_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mmn_in_if.sink       in_i,
  mmn_out_if.source    out_o
);

  logic       pp_valid, pp_ready;
  pp_sum_t    pp_data;
  logic       sum_valid, sum_ready;
  logic [ProdW-1:0] sum_prod;
  result_t    res;

  // Slice multiplies and the cross-product sum.
  mmn_pp u_pp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (in_i.ready),
    .mant_a_i (in_i.mant_a),
    .mant_b_i (in_i.mant_b),
    .valid_o  (pp_valid),
    .ready_i  (pp_ready),
    .data_o   (pp_data)
  );

  // Full product.
  mmn_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pp_valid),
    .ready_o (pp_ready),
    .data_i  (pp_data),
    .valid_o (sum_valid),
    .ready_i (sum_ready),
    .prod_o  (sum_prod)
  );

  // Normalization shift; its last stage is the output register.
  mmn_lzc u_lzc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .prod_i  (sum_prod),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.product_low   = res.product_low;
  assign out_o.product_high  = res.product_high;
  assign out_o.norm_shift    = res.norm_shift;
  assign out_o.overflow_flag = res.overflow_flag;

endmodule

### sv/mmn_chk.sv
// Port-level checker for the mantissa multiplier, bound to the top level.
// Depends on mmn_pkg for the field widths.
module mmn_chk import mmn_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [LowW-1:0]   product_low_i,
  input logic [HighW-1:0]  product_high_i,
  input logic [ShiftW-1:0] norm_shift_i,
  input logic              overflow_flag_i
);

  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] shifted;

  assign prod    = {product_high_i, product_low_i};
  assign shifted = prod << norm_shift_i;

  // A held result stays put until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(prod)
      && $stable(norm_shift_i) && $stable(overflow_flag_i))
    else $error("output changed while stalled");

  // The input side backs up only when the whole pipeline is full and stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  a_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> overflow_flag_i == product_high_i[HighW-1]
      && (!overflow_flag_i || norm_shift_i == ShiftOvf))
    else $error("overflow flag or its shift is wrong");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prod == '0 |-> norm_shift_i == '0 && !overflow_flag_i)
    else $error("zero product with nonzero shift");

  // Shifting by the reported amount lands the leading one on bit 104.
  a_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !overflow_flag_i && prod != '0 |-> shifted[ProdW-2])
    else $error("shift does not normalize the product");

endmodule

bind mantissa_multiplier_53x53_norm_top mmn_chk u_mmn_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .product_low_i   (out_o.product_low),
  .product_high_i  (out_o.product_high),
  .norm_shift_i    (out_o.norm_shift),
  .overflow_flag_i (out_o.overflow_flag)
);
